// ----- hw/rtl/tlet_pkg.sv -----
// Shared constants, types and the control store of the LED event table.
package tlet_pkg;

  localparam int SLOTS   = 8;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMD_W   = 2;
  localparam int TIME_W  = 32;
  localparam int LED_W   = 8;
  localparam int DEL_W   = 8;
  localparam int STAT_W  = 2;
  localparam int USED_W  = 3;
  localparam int CNT_W   = 4;
  localparam int ENTRY_W = TIME_W + LED_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [DEL_W-1:0] SLOTS_D  = DEL_W'(SLOTS);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  // Datapath action selected by one control word.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INS,
    ACT_FULL,
    ACT_DEL,
    ACT_PRIME,
    ACT_CMP,
    ACT_EMIT
  } act_t;

  // Next-step rule of one control word.
  typedef enum logic [2:0] {
    J_DISPATCH,
    J_NEXT,
    J_GOTO,
    J_SCAN,
    J_WAIT
  } jump_t;

  localparam int UPC_W     = 3;
  localparam int UPC_DEPTH = 1 << UPC_W;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_IDLE  = 3'd0;
  localparam upc_t UPC_INS   = 3'd1;
  localparam upc_t UPC_FULL  = 3'd2;
  localparam upc_t UPC_DEL   = 3'd3;
  localparam upc_t UPC_PRIME = 3'd4;
  localparam upc_t UPC_CMP   = 3'd5;
  localparam upc_t UPC_FIN   = 3'd6;
  localparam upc_t UPC_SPARE = 3'd7;

  typedef struct packed {
    act_t  act;
    jump_t jump;
    upc_t  target;
  } ucode_t;

  localparam ucode_t UCODE [UPC_DEPTH] = '{
    '{act: ACT_NONE,  jump: J_DISPATCH, target: UPC_IDLE},  // idle
    '{act: ACT_INS,   jump: J_SCAN,     target: UPC_FIN},   // probe for free slot
    '{act: ACT_FULL,  jump: J_GOTO,     target: UPC_FIN},   // table full
    '{act: ACT_DEL,   jump: J_GOTO,     target: UPC_FIN},   // delete
    '{act: ACT_PRIME, jump: J_NEXT,     target: UPC_IDLE},  // first tick read
    '{act: ACT_CMP,   jump: J_SCAN,     target: UPC_FIN},   // compare, next read
    '{act: ACT_EMIT,  jump: J_WAIT,     target: UPC_IDLE},  // hand off result
    '{act: ACT_NONE,  jump: J_GOTO,     target: UPC_IDLE}   // unused
  };

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic hit;
    logic last;
    logic out_free;
  } seq_flags_t;

  // Sequencer outputs that steer the datapath.
  typedef struct packed {
    act_t act;
    upc_t upc;
  } seq_ctrl_t;

endpackage

// ----- hw/rtl/tlet_if.sv -----
// Request and response channel interfaces of the LED event table.
interface tlet_req_if;
  import tlet_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TIME_W-1:0] alarm_time;
  logic [LED_W-1:0]  led_pattern;
  logic [DEL_W-1:0]  slot_to_delete;
  logic [TIME_W-1:0] current_time;

  modport source (
    output valid, command, alarm_time, led_pattern, slot_to_delete, current_time,
    input  ready
  );
  modport sink (
    input  valid, command, alarm_time, led_pattern, slot_to_delete, current_time,
    output ready
  );
endinterface

interface tlet_rsp_if;
  import tlet_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [USED_W-1:0] slot_used;
  logic              fired;
  logic [LED_W-1:0]  led_drive;
  logic [CNT_W-1:0]  active_count;

  modport source (
    output valid, status, slot_used, fired, led_drive, active_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot_used, fired, led_drive, active_count,
    output ready
  );
endinterface

// ----- hw/rtl/timed_led_event_table.sv -----
// Top level of the timed LED event table: slot store, datapath and result register.
//
//  channel  modport  role
//  -------  -------  -----------------------------------------------------------
//  req      sink     command plus insert, delete and tick operands
//  rsp      source   status, slot_used, fired, led_drive, active_count
//
// An item is taken only while the sequencer sits in its idle step; one item is
// worked at a time. After the transfer, an unused code goes straight to the result
// step, delete passes its delete step first, insert probes slots in order until one
// is free or all are full, and tick primes one read of the single slot RAM port
// and compares each slot as it is read. The result register frees the sequencer
// once loaded, so a new item is taken while the last result still waits on rsp.ready.
// Synchronous reset empties the table and drops any pending result; slot
// contents are not cleared, only their valid bits.
module timed_led_event_table (
  input logic clk,
  input logic rst,
  tlet_req_if.sink   req,
  tlet_rsp_if.source rsp
);
  import tlet_pkg::*;

  seq_ctrl_t  ctrl;
  seq_flags_t flags;
  logic       accept;

  // Table state: valid bits in flops, time and pattern in RAM.
  logic [SLOTS-1:0] slot_valid;
  logic [CNT_W-1:0] valid_total;

  // Operands held for the item in flight.
  logic [TIME_W-1:0] ev_time_q;
  logic [LED_W-1:0]  pattern_q;
  logic [DEL_W-1:0]  del_q;
  logic [TIME_W-1:0] now_q;

  // Scan pointers: idx addresses the RAM, cmp_idx tags the data coming back.
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W+USED_W-1:0] idx_wide;

  // Partial result of the item in flight.
  logic [STAT_W-1:0] res_status;
  logic [USED_W-1:0] res_used;
  logic              res_fired;
  logic [LED_W-1:0]  res_drive;

  // Result register toward rsp.
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [USED_W-1:0] out_used;
  logic              out_fired;
  logic [LED_W-1:0]  out_drive;
  logic [CNT_W-1:0]  out_count;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]  rd_time;
  logic [LED_W-1:0]   rd_leds;

  logic ins_free;
  logic del_ok;
  logic tick_match;
  logic out_free;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  tlet_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (req.command),
    .flags   (flags),
    .ctrl    (ctrl)
  );

  // Hold off requests while in reset.
  assign req.ready = !rst && (ctrl.upc == UPC_IDLE);
  assign accept    = req.valid && req.ready;

  // ---------------------------------------------------------------------------
  // Slot RAM: write on insert, read at the scan pointer every cycle
  // ---------------------------------------------------------------------------
  tlet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata ({ev_time_q, pattern_q}),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign rd_time = ram_rdata[ENTRY_W-1:LED_W];
  assign rd_leds = ram_rdata[LED_W-1:0];

  // ---------------------------------------------------------------------------
  // Datapath conditions
  // ---------------------------------------------------------------------------
  assign ins_free   = !slot_valid[idx];
  assign del_ok     = (del_q < SLOTS_D) && slot_valid[del_q[IDX_W-1:0]];
  assign tick_match = slot_valid[cmp_idx] && (rd_time == now_q);
  assign out_free   = !out_valid || rsp.ready;
  assign ram_we     = (ctrl.act == ACT_INS) && ins_free;

  // Slot index keeps its low bits only, whatever the table depth.
  assign idx_wide = {{USED_W{1'b0}}, idx};

  assign flags.hit      = (ctrl.act == ACT_INS) && ins_free;
  assign flags.last     = (ctrl.act == ACT_INS) ? (idx == LAST_IDX) : (cmp_idx == LAST_IDX);
  assign flags.out_free = out_free;

  // ---------------------------------------------------------------------------
  // Control state: valid bits, live count, result valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      valid_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Load a fresh result, else drop the one just transferred.
      priority if ((ctrl.act == ACT_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.act)
        ACT_INS: begin
          // Claim the probed slot if it is free.
          if (ins_free) begin
            slot_valid[idx] <= 1'b1;
            valid_total     <= valid_total + 4'd1;
          end
        end
        ACT_DEL: begin
          if (del_ok) begin
            slot_valid[del_q[IDX_W-1:0]] <= 1'b0;
            valid_total                  <= valid_total - 4'd1;
          end
        end
        ACT_CMP: begin
          // Free every slot whose time matches.
          if (tick_match) begin
            slot_valid[cmp_idx] <= 1'b0;
            valid_total         <= valid_total - 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Payload: operands, scan pointers, partial and final result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      ev_time_q  <= req.alarm_time;
      pattern_q  <= req.led_pattern;
      del_q      <= req.slot_to_delete;
      now_q      <= req.current_time;
      idx        <= '0;
      cmp_idx    <= '0;
      res_status <= ST_OK;
      res_used   <= '0;
      res_fired  <= 1'b0;
      res_drive  <= '0;
    end
    unique case (ctrl.act)
      ACT_INS: begin
        // Record the claimed slot, else advance the probe.
        if (ins_free) begin
          res_used <= idx_wide[USED_W-1:0];
        end else begin
          idx <= idx + 1'b1;
        end
      end
      ACT_FULL: res_status <= ST_FULL;
      ACT_DEL: begin
        if (!del_ok) begin
          res_status <= ST_NONE;
        end
      end
      ACT_PRIME: begin
        cmp_idx <= idx;
        idx     <= idx + 1'b1;
      end
      ACT_CMP: begin
        // Highest-index match wins the LED port.
        if (tick_match) begin
          res_fired <= 1'b1;
          res_drive <= rd_leds;
        end
        cmp_idx <= idx;
        idx     <= idx + 1'b1;
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_status <= res_status;
          out_used   <= res_used;
          out_fired  <= res_fired;
          out_drive  <= res_drive;
          out_count  <= valid_total;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.slot_used    = out_used;
  assign rsp.fired        = out_fired;
  assign rsp.led_drive    = out_drive;
  assign rsp.active_count = out_count;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    valid_total == CNT_W'($countones(slot_valid)))
    else $error("live count disagrees with valid bits");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (ctrl.upc != UPC_IDLE))
    else $error("sequencer stayed idle after a request transfer");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> slot_valid[$past(idx)])
    else $error("inserted slot not marked valid");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(ctrl.act) == ACT_EMIT))
    else $error("result loaded outside the emit step");

endmodule

// ----- hw/rtl/tlet_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tlet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/tlet_seq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
module tlet_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [tlet_pkg::CMD_W-1:0] command,
  input  tlet_pkg::seq_flags_t      flags,
  output tlet_pkg::seq_ctrl_t       ctrl
);
  import tlet_pkg::*;

  upc_t   upc;
  upc_t   upc_next;
  upc_t   dispatch;
  ucode_t cw;

  assign cw = UCODE[upc];

  always_comb begin
    unique case (command)
      CMD_INSERT: dispatch = UPC_INS;
      CMD_DELETE: dispatch = UPC_DEL;
      CMD_TICK:   dispatch = UPC_PRIME;
      default:    dispatch = UPC_FIN;
    endcase
  end

  always_comb begin
    unique case (cw.jump)
      J_DISPATCH: upc_next = accept ? dispatch : upc;
      J_NEXT:     upc_next = upc + 3'd1;
      J_GOTO:     upc_next = cw.target;
      J_SCAN: begin
        priority if (flags.hit) begin
          upc_next = cw.target;
        end else if (flags.last) begin
          upc_next = upc + 3'd1;
        end else begin
          upc_next = upc;
        end
      end
      J_WAIT:     upc_next = flags.out_free ? cw.target : upc;
      default:    upc_next = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctrl.act = cw.act;
  assign ctrl.upc = upc;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the timed LED event table: insert, delete and tick traffic.
module testbench;
  import tlet_pkg::*;

  // Command code that the block treats as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // How many mismatches get a full report before we only count them.
  localparam int REPORT_LIMIT = 10;

  // One request as the sender drives it, one response as the table returns it.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] alarm_time;
    logic [LED_W-1:0]  led_pattern;
    logic [DEL_W-1:0]  slot_to_delete;
    logic [TIME_W-1:0] current_time;
  } alarm_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [USED_W-1:0] slot_used;
    logic              fired;
    logic [LED_W-1:0]  led_drive;
    logic [CNT_W-1:0]  active_count;
  } alarm_rsp_t;

  logic clk;
  logic rst;

  tlet_req_if req_ch ();
  tlet_rsp_if rsp_ch ();

  timed_led_event_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the slot table, updated at every accepted request.
  bit                tbl_valid [SLOTS];
  logic [TIME_W-1:0] tbl_time  [SLOTS];
  logic [LED_W-1:0]  tbl_leds  [SLOTS];

  // Responses the table still owes us, oldest first.
  alarm_rsp_t pending_results [$];

  int  error_count;
  bit  gaps_on;          // both sides insert random idle cycles when set
  int  rsp_hold_cycles;  // one-shot long stall request for the receiver
  logic [TIME_W-1:0] time_base;

  // 8 ns clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard limit on the run; far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Predict the response of one request and advance the shadow table.
  function automatic alarm_rsp_t apply_command(alarm_req_t r);
    alarm_rsp_t o;
    bit         placed;
    int         n;
    o = '0;
    placed = 1'b0;
    n = 0;
    case (r.command)
      CMD_INSERT: begin
        o.status = ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_time[i]  = r.alarm_time;
            tbl_leds[i]  = r.led_pattern;
            o.slot_used  = USED_W'(i);
            o.status     = ST_OK;
            placed       = 1'b1;
          end
        end
      end
      CMD_DELETE: begin
        if (int'(r.slot_to_delete) < SLOTS && tbl_valid[int'(r.slot_to_delete)]) begin
          tbl_valid[int'(r.slot_to_delete)] = 1'b0;
        end else begin
          o.status = ST_NONE;
        end
      end
      CMD_TICK: begin
        // Every match is freed; the highest matching slot wins the LED port.
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_time[i] == r.current_time) begin
            tbl_valid[i] = 1'b0;
            o.fired      = 1'b1;
            o.led_drive  = tbl_leds[i];
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) n++;
    end
    o.active_count = CNT_W'(n);
    return o;
  endfunction

  function automatic alarm_req_t mk(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] etime,
                                    logic [LED_W-1:0] pat, logic [DEL_W-1:0] idx,
                                    logic [TIME_W-1:0] now);
    alarm_req_t r;
    r.command        = cmd;
    r.alarm_time     = etime;
    r.led_pattern    = pat;
    r.slot_to_delete = idx;
    r.current_time   = now;
    return r;
  endfunction

  // Drive one request and hold it until the transfer; predict at the accepting edge.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_item(alarm_req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.command        <= r.command;
    req_ch.alarm_time     <= r.alarm_time;
    req_ch.led_pattern    <= r.led_pattern;
    req_ch.slot_to_delete <= r.slot_to_delete;
    req_ch.current_time   <= r.current_time;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_command(r));
  endtask

  // Build a random request. Times cluster around time_base so that ticks hit
  // inserted entries; fields a command ignores carry random noise.
  function automatic alarm_req_t random_item();
    alarm_req_t r;
    int         roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 63) == 0) time_base = $urandom;
    r = mk(CMD_UNUSED, $urandom, LED_W'($urandom), DEL_W'($urandom), $urandom);
    if (roll < 36) begin
      r.command    = CMD_INSERT;
      r.alarm_time = time_base + TIME_W'($urandom_range(0, 5));
    end else if (roll < 56) begin
      r.command = CMD_DELETE;
      if (roll < 52) r.slot_to_delete = DEL_W'($urandom_range(0, SLOTS - 1));
    end else if (roll < 95) begin
      r.command      = CMD_TICK;
      r.current_time = time_base + TIME_W'($urandom_range(0, 5));
    end
    return r;
  endfunction

  // Receiver: draw a stall per response, or honor a one-shot long hold-off.
  initial begin : receiver
    int n;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (rsp_hold_cycles > 0) begin
        n = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end else begin
        n = gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Check every response transfer against the oldest prediction.
  always @(posedge clk) begin : check_results
    alarm_rsp_t got;
    alarm_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.status, rsp_ch.slot_used, rsp_ch.fired, rsp_ch.led_drive,
             rsp_ch.active_count};
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected response status=%0d slot=%0d fired=%0b led=%h cnt=%0d",
                   $realtime, got.status, got.slot_used, got.fired, got.led_drive,
                   got.active_count);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot_used !== want.slot_used ||
            got.fired !== want.fired || got.led_drive !== want.led_drive ||
            got.active_count !== want.active_count) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $write("%0t: mismatch exp status=%0d slot=%0d fired=%0b led=%h cnt=%0d",
                   $realtime, want.status, want.slot_used, want.fired, want.led_drive,
                   want.active_count);
            $display(" / got status=%0d slot=%0d fired=%0b led=%h cnt=%0d",
                     got.status, got.slot_used, got.fired, got.led_drive,
                     got.active_count);
          end
        end
      end
    end
  end

  // Empty table: tick with nothing to match, the unused code, delete of an empty slot.
  task automatic test_empty_table();
    send_item(mk(CMD_TICK, 32'h0, 8'h00, 8'h00, 32'h0));
    send_item(mk(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_item(mk(CMD_DELETE, 32'h0, 8'h00, 8'h00, 32'h0));
  endtask

  // Fill all slots with extreme times and patterns, then hit the full table.
  task automatic test_fill_and_full();
    send_item(mk(CMD_INSERT, 32'h0000_0000, 8'h00, 8'h00, 32'h0));
    send_item(mk(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'h00, 32'h0));
    send_item(mk(CMD_INSERT, 32'd5,         8'h80, 8'h00, 32'h0));
    send_item(mk(CMD_INSERT, 32'd5,         8'h01, 8'h00, 32'h0));
    send_item(mk(CMD_INSERT, 32'd5,         8'h30, 8'h00, 32'h0));
    send_item(mk(CMD_INSERT, 32'h8000_0000, 8'h55, 8'h00, 32'h0));
    send_item(mk(CMD_INSERT, 32'd7,         8'hAA, 8'h00, 32'h0));
    send_item(mk(CMD_INSERT, 32'hFFFF_FFFF, 8'h7F, 8'h00, 32'h0));
    send_item(mk(CMD_INSERT, 32'd9,         8'hC3, 8'h00, 32'h0));
  endtask

  // Delete out of range, delete a live slot, then the same slot again.
  task automatic test_delete_cases();
    send_item(mk(CMD_DELETE, 32'h0, 8'h00, SLOTS_D, 32'h0));
    send_item(mk(CMD_DELETE, 32'h0, 8'h00, 8'hFF, 32'h0));
    send_item(mk(CMD_DELETE, 32'h0, 8'h00, DEL_W'(SLOTS - 1), 32'h0));
    send_item(mk(CMD_DELETE, 32'h0, 8'h00, DEL_W'(SLOTS - 1), 32'h0));
  endtask

  // Ticks: several matches at once, a deleted duplicate, refill, a zero pattern.
  task automatic test_tick_matches();
    send_item(mk(CMD_TICK, 32'h0, 8'h00, 8'h00, 32'd5));
    send_item(mk(CMD_TICK, 32'h0, 8'h00, 8'h00, 32'hFFFF_FFFF));
    send_item(mk(CMD_INSERT, 32'd5, 8'h3C, 8'h00, 32'h0));
    send_item(mk(CMD_TICK, 32'h0, 8'h00, 8'h00, 32'h0));
    send_item(mk(CMD_TICK, 32'h0, 8'h00, 8'h00, 32'h8000_0000));
  endtask

  task automatic test_random_traffic(int count);
    gaps_on = 1'b1;
    repeat (count) send_item(random_item());
  endtask

  // Both sides at full rate.
  task automatic test_back_to_back(int count);
    gaps_on = 1'b0;
    repeat (count) send_item(random_item());
    gaps_on = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the result register fills and the table stalls its input.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    rsp_hold_cycles = 300;
    repeat (30) send_item(random_item());
    gaps_on = 1'b1;
  endtask

  initial begin
    error_count     = 0;
    gaps_on         = 1'b1;
    rsp_hold_cycles = 0;
    time_base       = $urandom;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    // Known values on every input before the first edge.
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.command        = CMD_INSERT;
    req_ch.alarm_time     = '0;
    req_ch.led_pattern    = '0;
    req_ch.slot_to_delete = '0;
    req_ch.current_time   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_fill_and_full();
    test_delete_cases();
    test_tick_matches();
    test_random_traffic(600);
    test_back_to_back(200);
    test_backpressure();
    test_random_traffic(470);
    req_ch.valid <= 1'b0;

    // Drain, then give the block a tick's worth of cycles for stray output.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * SLOTS) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
